/* src/rpv_pkg.sv */
package rpv_pkg;

    // Verdict reasons, in order of precedence for the whole-path checks.
    typedef enum logic [3:0] {
        RSN_OK       = 4'd0,
        RSN_EMPTY    = 4'd1,
        RSN_LONG     = 4'd2,
        RSN_LEADSEP  = 4'd3,
        RSN_DRIVE    = 4'd4,
        RSN_ILLEGAL  = 4'd5,
        RSN_EMPTYSEG = 4'd6,
        RSN_DOT      = 4'd7,
        RSN_DOTDOT   = 4'd8
    } reason_t;

    // Character codes that the scanner looks for.
    localparam logic [7:0] CH_CTRL_LAST = 8'd31;
    localparam logic [7:0] CH_DEL       = 8'd127;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_QUERY     = 8'h3F;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LESS      = 8'h3C;
    localparam logic [7:0] CH_GREATER   = 8'h3E;
    localparam logic [7:0] CH_PIPE      = 8'h7C;

    // Classification of one path byte.
    typedef struct packed {
        logic is_sep;
        logic is_bad;
        logic is_dot;
        logic is_colon;
    } byte_class_t;

endpackage

/* src/rpv_stream_if.sv */
// Path byte channel.
interface rpv_path_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

// Verdict channel.
interface rpv_verdict_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [3:0] reason;

    modport source (output valid, output accepted, output reason, input ready);
    modport sink   (input valid, input accepted, input reason, output ready);
endinterface

/* src/relative_path_validator.sv */
// Relative path validator. A path arrives on path_in one byte per transaction, and a
// transaction with is_end set stands for the terminator; its ch is ignored. For each
// terminator the block returns one verdict transaction on verdict_out: accepted is 1
// exactly when reason is 0 (ok), otherwise reason tells why the path was refused
// (1 empty, 2 too long, 3 leading separator, 4 drive letter, 5 illegal character,
// 6 empty segment, 7 "." segment, 8 ".." segment). Byte transactions give no verdict.
// The block sustains one transaction per clock cycle, bytes and terminators alike,
// since the scanner state is a handful of registers updated once a cycle from a short
// classification of the byte; a terminator waits while a previous verdict stalls. A
// terminator passes the input register and its verdict is held in an output register so
// bytes keep flowing while it waits. After reset the block is ready at once; there is
// no clearing pass. Paths over MAX_PATH_BYTES-1 characters are refused as too long.
module relative_path_validator #(
    parameter int MAX_PATH_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rpv_path_if.sink             path_in,
    rpv_verdict_if.source        verdict_out
);
    import rpv_pkg::*;

    // The character count saturates at MAX_PATH_BYTES-1, so it needs just enough
    // bits to hold that value.
    localparam int CNT_W = $clog2(MAX_PATH_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PATH_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Input register: the transaction most recently taken from path_in.
    logic       s1_valid_reg;
    logic [7:0] s1_ch_reg;
    logic       s1_end_reg;

    // Scanner state.
    logic [CNT_W-1:0] cnt_reg,      cnt_next;
    logic [1:0]       seg_len_reg,  seg_len_next;
    logic             all_dots_reg, all_dots_next;
    logic             ovf_reg,      ovf_next;
    logic             lead_reg,     lead_next;
    logic             drive_reg,    drive_next;
    reason_t          err_reg,      err_next;

    // Result register.
    logic    out_valid_reg, out_valid_next;
    logic    out_acc_reg,   out_acc_next;
    reason_t out_rsn_reg,   out_rsn_next;

    byte_class_t cls;
    logic        out_free;
    logic        s1_go;
    reason_t     close_code;
    reason_t     verdict;

    rpv_byte_class u_class (
        .ch  (s1_ch_reg),
        .cls (cls)
    );

    // A byte always moves on into the scanner; a terminator waits only while a
    // previous verdict is still held and not being taken.
    assign out_free      = !out_valid_reg || verdict_out.ready;
    assign s1_go         = s1_valid_reg && (!s1_end_reg || out_free);
    assign path_in.ready = !s1_valid_reg || s1_go;

    // What closing the current segment would report.
    always_comb
    begin
        if (seg_len_reg == 2'd0)
        begin
            close_code = RSN_EMPTYSEG;
        end
        else if (all_dots_reg && seg_len_reg == 2'd1)
        begin
            close_code = RSN_DOT;
        end
        else if (all_dots_reg && seg_len_reg == 2'd2)
        begin
            close_code = RSN_DOTDOT;
        end
        else
        begin
            close_code = RSN_OK;
        end
    end

    // Verdict at the terminator. A trailing empty segment is not closed, so only a
    // non-empty last segment can add a scan error, and only if none came before.
    always_comb
    begin
        if (cnt_reg == '0)
        begin
            verdict = RSN_EMPTY;
        end
        else if (ovf_reg)
        begin
            verdict = RSN_LONG;
        end
        else if (lead_reg)
        begin
            verdict = RSN_LEADSEP;
        end
        else if (drive_reg)
        begin
            verdict = RSN_DRIVE;
        end
        else if (err_reg != RSN_OK)
        begin
            verdict = err_reg;
        end
        else if (seg_len_reg != 2'd0)
        begin
            verdict = close_code;
        end
        else
        begin
            verdict = RSN_OK;
        end
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        seg_len_next   = seg_len_reg;
        all_dots_next  = all_dots_reg;
        ovf_next       = ovf_reg;
        lead_next      = lead_reg;
        drive_next     = drive_reg;
        err_next       = err_reg;
        out_acc_next   = out_acc_reg;
        out_rsn_next   = out_rsn_reg;
        out_valid_next = out_valid_reg && !verdict_out.ready;

        if (s1_go && !s1_end_reg)
        begin
            // Once the count is full it stays full, and every later byte is ignored.
            if (cnt_reg == CNT_MAX)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                if (cnt_reg == '0 && cls.is_sep)
                begin
                    lead_next = 1'b1;
                end
                if (cnt_reg == CNT_ONE && cls.is_colon)
                begin
                    drive_next = 1'b1;
                end
                if (cls.is_sep)
                begin
                    if (err_reg == RSN_OK)
                    begin
                        err_next = close_code;
                    end
                    seg_len_next  = 2'd0;
                    all_dots_next = 1'b1;
                end
                else
                begin
                    if (cls.is_bad && err_reg == RSN_OK)
                    begin
                        err_next = RSN_ILLEGAL;
                    end
                    if (seg_len_reg != 2'd3)
                    begin
                        seg_len_next = seg_len_reg + 2'd1;
                    end
                    if (!cls.is_dot)
                    begin
                        all_dots_next = 1'b0;
                    end
                end
                cnt_next = cnt_reg + CNT_ONE;
            end
        end
        else if (s1_go)
        begin
            out_valid_next = 1'b1;
            out_rsn_next   = verdict;
            out_acc_next   = (verdict == RSN_OK);
            cnt_next       = '0;
            seg_len_next   = 2'd0;
            all_dots_next  = 1'b1;
            ovf_next       = 1'b0;
            lead_next      = 1'b0;
            drive_next     = 1'b0;
            err_next       = RSN_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            seg_len_reg   <= 2'd0;
            all_dots_reg  <= 1'b1;
            ovf_reg       <= 1'b0;
            lead_reg      <= 1'b0;
            drive_reg     <= 1'b0;
            err_reg       <= RSN_OK;
        end
        else
        begin
            if (path_in.ready)
            begin
                s1_valid_reg <= path_in.valid;
            end
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            seg_len_reg   <= seg_len_next;
            all_dots_reg  <= all_dots_next;
            ovf_reg       <= ovf_next;
            lead_reg      <= lead_next;
            drive_reg     <= drive_next;
            err_reg       <= err_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (path_in.valid && path_in.ready)
        begin
            s1_ch_reg  <= path_in.ch;
            s1_end_reg <= path_in.is_end;
        end
        out_acc_reg <= out_acc_next;
        out_rsn_reg <= out_rsn_next;
    end

    assign verdict_out.valid    = out_valid_reg;
    assign verdict_out.accepted = out_acc_reg;
    assign verdict_out.reason   = out_rsn_reg;

endmodule

/* src/rpv_byte_class.sv */
module rpv_byte_class (
    input  logic [7:0]           ch,
    output rpv_pkg::byte_class_t cls
);
    import rpv_pkg::*;

    always_comb
    begin
        cls.is_sep   = ch inside {CH_SLASH, CH_BSLASH};
        cls.is_bad   = ch inside {[8'd0:CH_CTRL_LAST], CH_DEL, CH_COLON, CH_STAR,
                                  CH_QUERY, CH_QUOTE, CH_LESS, CH_GREATER, CH_PIPE};
        cls.is_dot   = (ch == CH_DOT);
        cls.is_colon = (ch == CH_COLON);
    end

endmodule

/* src/rpv_checker.sv */
module rpv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_is_end,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_accepted,
    input logic [3:0] out_reason
);
    import rpv_pkg::*;

    // A verdict is accepted exactly when its reason is ok.
    a_acc_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_accepted == (out_reason == RSN_OK)))
        else $error("accepted disagrees with reason");

    // A fresh verdict follows a terminator that has passed the input and result registers.
    a_verdict_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_is_end, 2))
        else $error("verdict without a terminator");

    // No verdict is shown while reset is held.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("verdict valid during reset");

    // A stalled verdict holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_accepted) && $stable(out_reason))
        else $error("stalled verdict changed");

endmodule

bind relative_path_validator rpv_checker u_rpv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (path_in.valid),
    .in_ready     (path_in.ready),
    .in_is_end    (path_in.is_end),
    .out_valid    (verdict_out.valid),
    .out_ready    (verdict_out.ready),
    .out_accepted (verdict_out.accepted),
    .out_reason   (verdict_out.reason)
);
